>>> rtl/ppso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppso_pkg
// Shared constants and codes for the polyline parallel-strip offset block.
// ----------------------------------------------------------------------------
package ppso_pkg;

  localparam int MAX_STRIPS_DEF = 16;
  localparam logic [31:0] PPD_RESET = 32'd256;
  localparam int Q30_SHIFT = 30;

  // Which normalization is running.
  localparam logic [1:0] JOB_SEG  = 2'd0;
  localparam logic [1:0] JOB_BIS1 = 2'd1;
  localparam logic [1:0] JOB_BIS2 = 2'd2;

  // Where a finished division result goes.
  localparam logic [1:0] DV_NA = 2'd0;
  localparam logic [1:0] DV_NB = 2'd1;
  localparam logic [1:0] DV_EX = 2'd2;
  localparam logic [1:0] DV_EY = 2'd3;

endpackage
`default_nettype wire

>>> rtl/polyline_parallel_strip_offset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_parallel_strip_offset
// Offsets each polyline vertex along its bisector normal, one point per strip.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: point_x, point_y, strip_count; tlast: line_end
// m_axis    out  tdata: out_x, out_y; tuser: strip_index, vertex_done;
//                tlast: line_done
// cfg       in   pixels_per_degree write
//
// One multiplier, one restoring square-root unit (one result bit per cycle)
// and one restoring divider are shared under a sequencer.
// A vertex needs up to two normalizations (three at the end of a line)
// plus two divisions per strip point.
// The first vertex of a line is only stored, with no work started. Input is not ready
// while a vertex is being worked on; a stalled output holds the sequencer.
// Reset is synchronous, returns the sequencer to idle, clears the line and vertex history and sets the scale to 256.
// ----------------------------------------------------------------------------
module polyline_parallel_strip_offset
  import ppso_pkg::*;
#(
  parameter int MAX_STRIPS = MAX_STRIPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] point_x, [63:32] point_y, [68:64] strip_count, rest zero
  input  wire logic [71:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] out_x, [63:32] out_y
  output logic [63:0]      m_tdata,
  // [3:0] strip_index, [4] vertex_done, rest zero
  output logic [7:0]       m_tuser,
  output logic             m_tlast
);

  localparam int SW = $clog2(MAX_STRIPS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQA  = 4'd1;
  localparam logic [3:0] S_SQB  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_POST = 4'd6;
  localparam logic [3:0] S_EX   = 4'd7;
  localparam logic [3:0] S_EY   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]        state;
  logic [1:0]        job;
  logic [1:0]        div_sel;
  logic [31:0]       ppd;
  logic [1:0]        points_seen;
  logic [SW-1:0]     line_strips;
  logic [SW-1:0]     strip;
  logic signed [31:0] held_x, held_y, in_x, in_y;
  logic              in_end;
  logic signed [31:0] nprev_x, nprev_y, ox, oy, ua, ub;
  logic signed [32:0] na, nb;
  logic [63:0]       srem, sroot, sbit;
  logic [63:0]       dnum;
  logic [33:0]       dden, drem;
  logic              dneg;
  logic [5:0]        cnt;
  logic signed [39:0] dispx;
  logic [31:0]       ox_r, oy_r;
  logic [3:0]        o_idx;
  logic              o_vdone, o_ldone;

  // Segment from the held vertex to the incoming one, halved when too long.
  logic signed [32:0] dx, dy, dxh, dyh;
  logic              big;
  always_comb begin
    dx = {s_tdata[31], s_tdata[31:0]} - {held_x[31], held_x};
    dy = {s_tdata[63], s_tdata[63:32]} - {held_y[31], held_y};
    big = (dx > 33'sd2147483647) || (dx < -33'sd2147483647) ||
          (dy > 33'sd2147483647) || (dy < -33'sd2147483647);
    dxh = dx;
    dyh = dy;
    if (big) begin
      dxh = (dx + $signed({32'd0, dx[32]})) >>> 1;
      dyh = (dy + $signed({32'd0, dy[32]})) >>> 1;
    end
  end

  logic [31:0] abs_na, abs_nb, abs_ua, abs_ub;
  assign abs_na = na[32] ? 32'(-na) : na[31:0];
  assign abs_nb = nb[32] ? 32'(-nb) : nb[31:0];
  assign abs_ua = ua[31] ? -ua : ua;
  assign abs_ub = ub[31] ? -ub : ub;

  // Strip offset factor k = 2j - n + 1.
  logic signed [SW+1:0] k;
  logic [SW+1:0]        kmag;
  logic                 last_strip;
  assign k = $signed({1'b0, strip, 1'b0}) - $signed({2'b00, line_strips}) +
             $signed((SW + 2)'(1));
  assign kmag = k[SW+1] ? (SW + 2)'(-k) : k;
  assign last_strip = ({1'b0, strip} + (SW + 1)'(1)) == {1'b0, line_strips};

  logic [31:0] ppd1;
  assign ppd1 = (ppd == 32'd0) ? 32'd1 : ppd;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      S_SQA: begin mul_a = abs_na; mul_b = abs_na; end
      S_SQB: begin mul_a = abs_nb; mul_b = abs_nb; end
      S_EX:  begin mul_a = abs_ua; mul_b = {{(30 - SW){1'b0}}, kmag}; end
      S_EY:  begin mul_a = abs_ub; mul_b = {{(30 - SW){1'b0}}, kmag}; end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // Square-root step; sq_fin is the root after this step.
  logic [64:0] sq_try;
  logic        sq_take;
  logic [63:0] sq_fin;
  assign sq_try = {1'b0, sroot} + {1'b0, sbit};
  assign sq_take = {1'b0, srem} >= sq_try;
  assign sq_fin = sq_take ? (sroot >> 1) + sbit : sroot >> 1;

  // Divider step; the quotient shifts into dnum.
  logic [34:0] dv_t;
  logic        dv_take;
  logic [63:0] dv_q;
  logic [63:0] dv_qs;
  assign dv_t = {drem, dnum[63]};
  assign dv_take = dv_t >= {1'b0, dden};
  assign dv_q = {dnum[62:0], dv_take};
  assign dv_qs = dneg ? -dv_q : dv_q;

  // Offset point with saturation.
  logic signed [40:0] sum_x, sum_y;
  logic signed [39:0] dispy;
  logic [31:0]        sat_x, sat_y;
  assign dispy = dv_qs[39:0];
  always_comb begin
    sum_x = {{9{held_x[31]}}, held_x} + {dispx[39], dispx};
    sum_y = {{9{held_y[31]}}, held_y} + {dispy[39], dispy};
    if (sum_x > 41'sd2147483647) sat_x = 32'h7FFF_FFFF;
    else if (sum_x < -41'sd2147483648) sat_x = 32'h8000_0000;
    else sat_x = sum_x[31:0];
    if (sum_y > 41'sd2147483647) sat_y = 32'h7FFF_FFFF;
    else if (sum_y < -41'sd2147483648) sat_y = 32'h8000_0000;
    else sat_y = sum_y[31:0];
  end

  logic [4:0] sc;
  assign sc = s_tdata[68:64];

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {oy_r, ox_r};
  assign m_tuser  = {3'b000, o_vdone, o_idx};
  assign m_tlast  = o_ldone;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ppd         <= PPD_RESET;
      points_seen <= 2'd0;
      line_strips <= SW'(1);
      held_x      <= '0;
      held_y      <= '0;
      nprev_x     <= '0;
      nprev_y     <= '0;
    end else begin
      if (cfg_wr_en) ppd <= cfg_wr_data;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (points_seen == 2'd0) begin
              if (sc == 5'd0) line_strips <= SW'(1);
              else if ({1'b0, sc} > 6'(MAX_STRIPS)) line_strips <= SW'(MAX_STRIPS);
              else line_strips <= SW'(sc);
              held_x      <= s_tdata[31:0];
              held_y      <= s_tdata[63:32];
              points_seen <= s_tlast ? 2'd0 : 2'd1;
            end else begin
              in_x   <= s_tdata[31:0];
              in_y   <= s_tdata[63:32];
              in_end <= s_tlast;
              na     <= -dyh;
              nb     <= dxh;
              job    <= JOB_SEG;
              state  <= S_SQA;
            end
          end
        end
        S_SQA: begin
          srem  <= prod;
          state <= S_SQB;
        end
        S_SQB: begin
          srem  <= srem + prod;
          state <= S_CHK;
        end
        S_CHK: begin
          // Segments drop only at zero length; a bisector also at length one.
          if ((job == JOB_SEG) ? (srem == 64'd0) : (srem <= 64'd1)) begin
            ua    <= '0;
            ub    <= '0;
            state <= S_POST;
          end else begin
            sroot <= 64'd0;
            sbit  <= 64'd1 << 62;
            cnt   <= 6'd0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          sroot <= sq_fin;
          sbit  <= sbit >> 2;
          if (sq_take) srem <= srem - sq_try[63:0];
          if (cnt == 6'd31) begin
            state   <= S_DIV;
            dnum    <= ({32'd0, abs_na} << Q30_SHIFT) + (sq_fin >> 1);
            dden    <= (sq_fin == 64'd0) ? 34'd1 : 34'(sq_fin);
            dneg    <= na[32];
            drem    <= '0;
            div_sel <= DV_NA;
            cnt     <= 6'd0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          if (cnt != 6'd63) begin
            drem <= dv_take ? 34'(dv_t - {1'b0, dden}) : dv_t[33:0];
            dnum <= dv_q;
            cnt  <= cnt + 6'd1;
          end else begin
            cnt  <= 6'd0;
            drem <= '0;
            unique case (div_sel)
              DV_NA: begin
                ua      <= dv_qs[31:0];
                dnum    <= ({32'd0, abs_nb} << Q30_SHIFT) + (sroot >> 1);
                dneg    <= nb[32];
                div_sel <= DV_NB;
              end
              DV_NB: begin
                ub    <= dv_qs[31:0];
                state <= S_POST;
              end
              DV_EX: begin
                dispx <= dv_qs[39:0];
                state <= S_EY;
              end
              DV_EY: begin
                ox_r    <= sat_x;
                oy_r    <= sat_y;
                o_idx   <= 4'(strip);
                o_vdone <= last_strip;
                o_ldone <= last_strip && (job == JOB_BIS2);
                state   <= S_OUT;
              end
              default: ;
            endcase
          end
        end
        S_POST: begin
          if (job == JOB_SEG) begin
            ox <= ua;
            oy <= ub;
            // The incoming normal is the outgoing one of the previous vertex.
            if (points_seen == 2'd2) begin
              na <= {nprev_x[31], nprev_x} + {ua[31], ua};
              nb <= {nprev_y[31], nprev_y} + {ub[31], ub};
            end else begin
              na <= {ua[31], ua};
              nb <= {ub[31], ub};
            end
            job   <= JOB_BIS1;
            state <= S_SQA;
          end else begin
            strip <= '0;
            state <= S_EX;
          end
        end
        S_EX: begin
          dnum    <= prod + {32'd0, ppd1};
          dden    <= {1'b0, ppd1, 1'b0};
          dneg    <= ua[31] ^ k[SW+1];
          drem    <= '0;
          cnt     <= 6'd0;
          div_sel <= DV_EX;
          state   <= S_DIV;
        end
        S_EY: begin
          dnum    <= prod + {32'd0, ppd1};
          dneg    <= ub[31] ^ k[SW+1];
          drem    <= '0;
          cnt     <= 6'd0;
          div_sel <= DV_EY;
          state   <= S_DIV;
        end
        S_OUT: begin
          if (m_tready) begin
            if (!last_strip) begin
              strip <= strip + SW'(1);
              state <= S_EX;
            end else if (job == JOB_BIS1) begin
              held_x      <= in_x;
              held_y      <= in_y;
              nprev_x     <= ox;
              nprev_y     <= oy;
              points_seen <= 2'd2;
              if (in_end) begin
                na    <= {ox[31], ox};
                nb    <= {oy[31], oy};
                job   <= JOB_BIS2;
                state <= S_SQA;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              points_seen <= 2'd0;
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline parallel-strip offset testbench
// Feeds polylines of random shape and strip count through the offset block,
// predicts every offset point with a bit-exact software model of the
// fixed-point bisector math, and compares each output transaction in order.
// ----------------------------------------------------------------------------

class offset_scoreboard;
  logic [31:0] scale;
  longint older_x, older_y, held_x, held_y;
  int unsigned points_seen;
  int unsigned line_strips;
  logic [69:0] expected_points[$];  // {line_done, vertex_done, strip[3:0], y, x}
  int unsigned error_count;

  function new();
    scale = 32'd256;
    older_x = 0; older_y = 0; held_x = 0; held_y = 0;
    points_seen = 0;
    line_strips = 1;
    error_count = 0;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rounds to nearest with halves away from zero; magnitudes stay well below 2^63.
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit unit_normal(longint ax, longint ay, longint bx, longint by,
                                     output longint nx, output longint ny);
    longint dx, dy;
    longint unsigned len;
    dx = bx - ax;
    dy = by - ay;
    nx = 0;
    ny = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dx >= 64'sd2147483648 || dx <= -64'sd2147483648 ||
        dy >= 64'sd2147483648 || dy <= -64'sd2147483648) begin
      dx = dx / 2;
      dy = dy / 2;
    end
    len = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
    nx = round_div(-dy * (64'sd1 << 30), len);
    ny = round_div(dx * (64'sd1 << 30), len);
    return 1;
  endfunction

  function automatic void bisect(bit ok_a, longint ax, longint ay, bit ok_b, longint bx,
                                 longint by, output longint ux, output longint uy);
    longint mx, my;
    longint unsigned ss, l;
    mx = 0;
    my = 0;
    if (ok_a) begin mx += ax; my += ay; end
    if (ok_b) begin mx += bx; my += by; end
    ss = longint'(mx * mx) + longint'(my * my);
    ux = 0;
    uy = 0;
    if (ss <= 1) return;
    l = floor_sqrt(ss);
    ux = round_div(mx * (64'sd1 << 30), l);
    uy = round_div(my * (64'sd1 << 30), l);
  endfunction

  function automatic void push_vertex(longint px, longint py, longint ux, longint uy,
                                      bit last);
    longint unsigned den;
    longint k, qx, qy;
    logic [3:0] strip;
    den = ((scale == 0) ? 64'd1 : longint'(scale)) * 2;
    for (int j = 0; j < line_strips; j++) begin
      k = 2 * j - longint'(line_strips) + 1;
      qx = clamp32(px + round_div(ux * k, den));
      qy = clamp32(py + round_div(uy * k, den));
      strip = j[3:0];
      expected_points.push_back({last && (j + 1 == line_strips), j + 1 == line_strips,
                                 strip, qy[31:0], qx[31:0]});
    end
  endfunction

  function void note_vertex(logic [31:0] x_in, logic [31:0] y_in, logic [4:0] strips,
                            bit line_end);
    longint px, py, ix, iy, ox, oy, ux, uy;
    bit ok_in, ok_out;
    px = longint'($signed(x_in));
    py = longint'($signed(y_in));
    ix = 0;
    iy = 0;
    ok_in = 0;
    if (points_seen == 0) begin
      line_strips = (strips == 0) ? 1 : (strips > 16) ? 16 : strips;
      held_x = px;
      held_y = py;
      points_seen = line_end ? 0 : 1;
      return;
    end
    if (points_seen >= 2) ok_in = unit_normal(older_x, older_y, held_x, held_y, ix, iy);
    ok_out = unit_normal(held_x, held_y, px, py, ox, oy);
    bisect(ok_in, ix, iy, ok_out, ox, oy, ux, uy);
    push_vertex(held_x, held_y, ux, uy, 0);
    older_x = held_x;
    older_y = held_y;
    held_x = px;
    held_y = py;
    points_seen = 2;
    if (line_end) begin
      bisect(ok_out, ox, oy, 0, 0, 0, ux, uy);
      push_vertex(held_x, held_y, ux, uy, 1);
      points_seen = 0;
    end
  endfunction

  function void check_point(logic [63:0] tdata, logic [7:0] tuser, logic tlast);
    logic [69:0] want;
    if (expected_points.size() == 0) begin
      $error("unexpected offset point x=%h y=%h", tdata[31:0], tdata[63:32]);
      error_count++;
      return;
    end
    want = expected_points.pop_front();
    if (tdata[31:0] !== want[31:0]) begin
      $error("out_x expected %h actual %h", want[31:0], tdata[31:0]);
      error_count++;
    end
    if (tdata[63:32] !== want[63:32]) begin
      $error("out_y expected %h actual %h", want[63:32], tdata[63:32]);
      error_count++;
    end
    if (tuser[3:0] !== want[67:64]) begin
      $error("strip_index expected %0d actual %0d", want[67:64], tuser[3:0]);
      error_count++;
    end
    if (tuser[4] !== want[68]) begin
      $error("vertex_done expected %b actual %b", want[68], tuser[4]);
      error_count++;
    end
    if (tlast !== want[69]) begin
      $error("line_done expected %b actual %b", want[69], tlast);
      error_count++;
    end
  endfunction
endclass

module testbench;
  import ppso_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [7:0] m_tuser;
  logic m_tlast;

  offset_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  always #5 clk = ~clk;

  polyline_parallel_strip_offset i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_point(m_tdata, m_tuser, m_tlast);
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Leaves tvalid high on return so back-to-back vertices need no gap; callers
  // drop it before anything else happens on the bus.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [4:0] strips, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, strips, y, x};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    board.note_vertex(x, y, strips, last);
    @(negedge clk);
  endtask

  task automatic write_scale(logic [31:0] value);
    s_tvalid <= 1'b0;
    while (board.expected_points.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.scale = value;
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(2000) - 1000 + ($urandom_range(1) ? 32'h0 : $urandom());
    endcase
  endfunction

  // A polyline of the given number of points; points wander locally or jump at random.
  task automatic send_line(int points, logic [4:0] strips);
    logic [31:0] x, y;
    x = random_coord();
    y = random_coord();
    for (int p = 0; p < points; p++) begin
      send_vertex(x, y, strips, p == points - 1);
      if ($urandom_range(7) == 0) begin
        // repeated vertex gives a zero-length segment
      end else if ($urandom_range(3) == 0) begin
        x = random_coord();
        y = random_coord();
      end else begin
        x = x + $urandom_range(1 << 20) - (1 << 19);
        y = y + $urandom_range(1 << 20) - (1 << 19);
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: one-point line, extremes, zero/oversized strip counts, zero scale.
    send_vertex(32'h1234_5678, 32'h0, 5'd3, 1);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd16, 0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 5'd16, 0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 5'd16, 0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 5'd16, 1);
    send_vertex(32'h0, 32'h0, 5'd0, 0);
    send_vertex(32'h0, 32'h0, 5'd0, 1);
    send_vertex(32'h100, 32'h0, 5'd31, 0);
    send_vertex(32'h0, 32'h100, 5'd1, 0);
    send_vertex(32'hFFFF_FF00, 32'h0, 5'd2, 1);
    write_scale(32'd0);
    send_line(3, 5'd4);
    write_scale(32'hFFFF_FFFF);
    send_line(3, 5'd16);
    write_scale(32'd1);
    send_line(4, 5'd5);
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 12) : 0;
      recv_stall_pct = (phase == 2) ? 59 : (phase == 3) ? 12 : 0;
      write_scale((phase == 0) ? 32'd256 : $urandom_range(1 << 16, 1));
      for (int n = 0; n < 50;) begin
        int len;
        len = $urandom_range(6, 1);
        send_line(len, ($urandom_range(9) == 0) ? 5'($urandom_range(31)) :
                       (($urandom_range(4) == 0) ? 5'd16 : 5'($urandom_range(4, 1))));
        n += len;
      end
    end
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (board.expected_points.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (board.error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #60ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
